@@ design/keypad_scan_debounce_queue_assert.svh @@
// ----------------------------------------------------------------------------
// keypad scanner assertion macros
// shorthand for clocked assertions on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_DEBOUNCE_QUEUE_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCE_QUEUE_ASSERT_SVH

// condition in the same cycle
`define KPSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// condition in the next cycle
`define KPSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/kpsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_pkg
// shared types, constants and the keymap of the keypad scanner
// ----------------------------------------------------------------------------
package kpsd_pkg;

    localparam int COL_COUNT        = 4;
    localparam int COL_W            = 2;
    localparam int SAMPLE_ROWS      = 4;
    localparam int KEY_W            = 4;
    localparam int CHAR_W           = 7;
    localparam int DEF_ROW_COUNT    = 4;
    localparam int DEF_HISTORY_BITS = 8;

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    // what the key ring reports for one transaction
    typedef struct packed {
        logic              key_valid;
        logic [KEY_W-1:0]  key_index;
        logic [CHAR_W-1:0] key_char;
        logic              key_waiting;
    } pop_result_t;

    // one result item as held in the output queue
    typedef struct packed {
        logic [COL_COUNT-1:0] column_drive;
        pop_result_t          pop;
    } out_item_t;

    // keymap " CBA#9630852:741"
    function automatic logic [CHAR_W-1:0] key_char_f(input logic [KEY_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        unique case (idx)
            4'd0:  ch = 7'h20;
            4'd1:  ch = 7'h43;
            4'd2:  ch = 7'h42;
            4'd3:  ch = 7'h41;
            4'd4:  ch = 7'h23;
            4'd5:  ch = 7'h39;
            4'd6:  ch = 7'h36;
            4'd7:  ch = 7'h33;
            4'd8:  ch = 7'h30;
            4'd9:  ch = 7'h38;
            4'd10: ch = 7'h35;
            4'd11: ch = 7'h32;
            4'd12: ch = 7'h3a;
            4'd13: ch = 7'h37;
            4'd14: ch = 7'h34;
            4'd15: ch = 7'h31;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

@@ design/kpsd_row_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_row_lane
// debounce histories of one keypad row, one per column, with press detect
// ----------------------------------------------------------------------------
module kpsd_row_lane #(
    parameter int HISTORY_BITS = kpsd_pkg::DEF_HISTORY_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      scan_en,
    input  wire logic [kpsd_pkg::COL_W-1:0] column,
    input  wire logic                      row_bit,
    output logic                           push
);
    import kpsd_pkg::*;

    logic [HISTORY_BITS-1:0] hist_reg [COL_COUNT];
    logic [HISTORY_BITS-1:0] hist_next;

    assign hist_next = {hist_reg[column][HISTORY_BITS-2:0], row_bit};
    // HISTORY_BITS-1 lows then a high: a clean new press
    assign push = scan_en && (hist_next == HISTORY_BITS'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < COL_COUNT; c++) begin
                hist_reg[c] <= '0;
            end
        end else if (scan_en) begin
            hist_reg[column] <= hist_next;
        end
    end

endmodule
`default_nettype wire

@@ design/kpsd_key_ring.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_key_ring
// merges the lanes' presses in row order into a two-slot ring, serves pops
// ----------------------------------------------------------------------------
module kpsd_key_ring #(
    parameter int ROW_COUNT = kpsd_pkg::DEF_ROW_COUNT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       scan_en,
    input  wire logic                       pop_en,
    input  wire logic [kpsd_pkg::COL_W-1:0] column,
    input  wire logic [ROW_COUNT-1:0]       push,
    output kpsd_pkg::pop_result_t           result
);
    import kpsd_pkg::*;

    logic [KEY_W-1:0] slot_key_reg  [2];
    logic [KEY_W-1:0] slot_key_next [2];
    logic [1:0]       full_reg, full_next;
    logic             wr_reg, wr_next;
    logic             rd_reg, rd_next;
    logic [KEY_W-1:0] key;

    always_comb begin
        slot_key_next = slot_key_reg;
        full_next     = full_reg;
        wr_next       = wr_reg;
        rd_next       = rd_reg;
        key           = '0;
        result        = '0;
        if (scan_en) begin
            // ascending row order, each push moves the write slot
            for (int r = 0; r < ROW_COUNT; r++) begin
                key = KEY_W'(int'(column) * ROW_COUNT + r);
                if (push[r]) begin
                    slot_key_next[wr_next] = key;
                    full_next[wr_next]     = 1'b1;
                    wr_next                = ~wr_next;
                end
            end
        end else if (pop_en && full_reg[rd_reg]) begin
            result.key_valid = 1'b1;
            result.key_index = slot_key_reg[rd_reg];
            result.key_char  = key_char_f(slot_key_reg[rd_reg]);
            full_next[rd_reg] = 1'b0;
            rd_next           = ~rd_reg;
        end
        result.key_waiting = full_next[rd_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= '0;
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
        end else begin
            full_reg <= full_next;
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_key_reg <= slot_key_next;
    end

endmodule
`default_nettype wire

@@ design/keypad_scan_debounce_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_scan_debounce_queue
// 4-column matrix keypad scanner with shift-register debounce and key ring
// ----------------------------------------------------------------------------
// Every input transaction is either a scan tick, carrying the row levels of
// the column now driven, or a pop. A scan tick shifts each row's level into
// that key's debounce history (one lane per row, working in parallel); a
// history of all lows but the newest high counts as a press and pushes the
// key index into a two-slot ring, several presses of one tick in ascending
// row order, a third unread press overwriting a slot. The column then
// advances modulo 4. A pop returns the oldest key and its keymap character.
// Each transaction yields exactly one result transaction. Throughput is one
// transaction per cycle while the two-entry output queue has room; the
// queue registers each result before the master side sees it, and the
// slave side stays ready while one result waits for m_tready. The state
// update is a combinational lane compare plus ring merge.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_queue #(
    parameter int ROW_COUNT    = kpsd_pkg::DEF_ROW_COUNT,
    parameter int HISTORY_BITS = kpsd_pkg::DEF_HISTORY_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] row_sample, [7:4] zero
    input  wire logic [0:0]  s_tuser,   // [0] opcode
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0] m_tdata,        // [3:0] column_drive, [7:4] key_index,
                                        // [14:8] key_char, [15] key_waiting
    output logic [0:0]  m_tuser         // [0] key_valid
);
    import kpsd_pkg::*;

    // handshake
    logic s_accept;
    logic m_accept;
    logic scan_en;
    logic pop_en;

    // scan column
    logic [COL_W-1:0] col_reg, col_next;

    // lanes and ring
    logic [ROW_COUNT-1:0] push;
    pop_result_t          ring_result;
    out_item_t            item;

    // output queue
    out_item_t   q_data_reg [2];
    logic        q_wr_reg, q_rd_reg;
    logic [1:0]  q_count_reg;

    assign s_tready = (q_count_reg != 2'd2);
    assign m_tvalid = (q_count_reg != 2'd0);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign scan_en  = s_accept && (opcode_t'(s_tuser[0]) == OP_SCAN);
    assign pop_en   = s_accept && (opcode_t'(s_tuser[0]) == OP_POP);

    assign col_next = scan_en ? col_reg + COL_W'(1) : col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    // one lane per row; rows past the sampled four always read low
    for (genvar r = 0; r < ROW_COUNT; r++) begin : g_lane
        logic row_bit;
        if (r < SAMPLE_ROWS) begin : g_live
            assign row_bit = s_tdata[r];
        end else begin : g_dead
            assign row_bit = 1'b0;
        end
        kpsd_row_lane #(
            .HISTORY_BITS (HISTORY_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .scan_en (scan_en),
            .column  (col_reg),
            .row_bit (row_bit),
            .push    (push[r])
        );
    end

    // merge of lane presses and pop service
    kpsd_key_ring #(
        .ROW_COUNT (ROW_COUNT)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .scan_en (scan_en),
        .pop_en  (pop_en),
        .column  (col_reg),
        .push    (push),
        .result  (ring_result)
    );

    // result of this transaction: column drive reflects the column after it, advanced only by a scan
    assign item.column_drive = COL_COUNT'(1) << col_next;
    assign item.pop          = ring_result;

    // two-entry output queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg    <= 1'b0;
            q_rd_reg    <= 1'b0;
            q_count_reg <= '0;
        end else begin
            if (s_accept) begin
                q_wr_reg <= ~q_wr_reg;
            end
            if (m_accept) begin
                q_rd_reg <= ~q_rd_reg;
            end
            if (s_accept && !m_accept) begin
                q_count_reg <= q_count_reg + 2'd1;
            end else if (m_accept && !s_accept) begin
                q_count_reg <= q_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            q_data_reg[q_wr_reg] <= item;
        end
    end

    // pack the head result onto the master side
    always_comb begin
        m_tdata        = '0;
        m_tdata[3:0]   = q_data_reg[q_rd_reg].column_drive;
        m_tdata[7:4]   = q_data_reg[q_rd_reg].pop.key_index;
        m_tdata[14:8]  = q_data_reg[q_rd_reg].pop.key_char;
        m_tdata[15]    = q_data_reg[q_rd_reg].pop.key_waiting;
        m_tuser[0]     = q_data_reg[q_rd_reg].pop.key_valid;
    end

endmodule
`default_nettype wire

@@ design/kpsd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpsd_checker
// port-level checks of the keypad scanner, bound to the top level
// ----------------------------------------------------------------------------
`include "keypad_scan_debounce_queue_assert.svh"

module kpsd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // a stalled result transaction holds
    `KPSD_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // exactly one column is driven
    `KPSD_ASSERT_SAME(a_col_onehot, m_tvalid, $onehot(m_tdata[3:0]), "column drive not one-hot")

    // no key returned means index and character are zero
    `KPSD_ASSERT_SAME(a_nokey_zero, m_tvalid && !m_tuser[0], m_tdata[14:4] == 11'd0, "key fields set without a key")

    // every keymap character is printable, so a returned key never has char zero
    `KPSD_ASSERT_SAME(a_key_char, m_tvalid && m_tuser[0], m_tdata[14:8] != 7'd0, "returned key has empty character")

endmodule

bind keypad_scan_debounce_queue kpsd_checker u_kpsd_checker (.*);
`default_nettype wire
